/* rtl/scr_pkg.sv */
`default_nettype none

package scr_pkg;

    // Fixed field widths of the stream channels
    localparam int PAGE_IN_W = 16;
    localparam int CFG_W     = 4;
    localparam int SLOT_W    = 3;
    localparam int FAULT_W   = 16;
    localparam int M_TDATA_W = 24;

    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [FAULT_W-1:0] fault_t;

    // Frame count after reset
    localparam cfg_t FRAMES_RESET = cfg_t'(8);

    // Fault counter ceiling
    localparam fault_t FAULT_MAX = '1;

endpackage

`default_nettype wire

/* rtl/scr_page_ram.sv */
`default_nettype none

// Page number store: one write port, one read port with registered data
module scr_page_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the placed page
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/second_chance_page_replacement.sv */
`default_nettype none

// Channel   | Direction | Signals                      | Contents (lowest bit first)
// ----------+-----------+------------------------------+------------------------------------
// s_*       | in        | s_tvalid s_tready s_tdata    | page_number[15:0]
// m_*       | out       | m_tvalid m_tready m_tdata    | frame_slot[2:0] fault_count[18:3]
//           |           | m_tuser                      | hit
// cfg_*     | in        | cfg_valid cfg_ready cfg_data | frames_in_use[3:0]
//
// One reference at a time. With n active frames, a hit stops the search at the
// frame found, and a miss searches all n frames before the sweep: the single
// compare unit walks one frame a cycle over the page store read port, then the
// hand sweeps one reference bit a cycle.
// A finished result waits in the output register while the next reference
// is taken. Reset clears valid and reference bits, hand and fault count.
module second_chance_page_replacement
    import scr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PAGE_IN_W-1:0] s_tdata,   // page_number
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // frame_slot, fault_count, zero pad
    output logic [0:0]                m_tuser,   // hit
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data   // frames_in_use
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SWEEP  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]            state_reg,   state_next;
    logic [IDX_W-1:0]      idx_reg,     idx_next;
    logic [IDX_W-1:0]      last_reg,    last_next;
    logic [IDX_W-1:0]      hand_reg,    hand_next;
    logic [MAX_FRAMES-1:0] valid_reg,   valid_next;
    logic [MAX_FRAMES-1:0] ref_reg,     ref_next;
    fault_t                fault_reg,   fault_next;
    cfg_t                  frames_reg,  frames_next;
    logic                  out_valid_reg, out_valid_next;

    logic [PAGE_BITS-1:0]  page_reg,      page_next;
    logic                  pend_hit_reg,  pend_hit_next;
    logic [IDX_W-1:0]      pend_slot_reg, pend_slot_next;
    logic                  out_hit_reg,   out_hit_next;
    slot_t                 out_slot_reg,  out_slot_next;
    fault_t                out_fault_reg, out_fault_next;

    logic [CW-1:0]         cfg_ext;
    logic [CW-1:0]         n_full;
    logic [PAGE_BITS-1:0]  page_in;
    logic [IDX_W-1:0]      rd_addr;
    logic [PAGE_BITS-1:0]  rd_data;
    logic                  ram_we;
    logic                  in_xfer;
    logic                  out_free;
    logic [IDX_W-1:0]      idx_inc;

    scr_page_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (PAGE_BITS),
        .AW    (IDX_W)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (page_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign page_in   = PAGE_BITS'(s_tdata);
    assign idx_inc   = (idx_reg == last_reg) ? '0 : idx_reg + IDX_W'(1);

    // Clamp the frame count into 1..MAX_FRAMES
    always_comb
    begin
        cfg_ext = CW'(frames_reg);
        if (cfg_ext == '0)
        begin
            n_full = CW'(1);
        end
        else if (cfg_ext > CW'(MAX_FRAMES))
        begin
            n_full = CW'(MAX_FRAMES);
        end
        else
        begin
            n_full = cfg_ext;
        end
    end

    // Read the frame the compare unit looks at next cycle
    assign rd_addr = (state_reg == ST_IDLE) ? '0 : idx_inc;

    // Sequencer: search, sweep, hand over result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        ref_next       = ref_reg;
        fault_next     = fault_reg;
        frames_next    = frames_reg;
        out_valid_next = out_valid_reg;
        page_next      = page_reg;
        pend_hit_next  = pend_hit_reg;
        pend_slot_next = pend_slot_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_fault_next = out_fault_reg;
        ram_we         = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            frames_next = cfg_data;
        end

        // Drop the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    page_next  = page_in;
                    last_next  = IDX_W'(n_full - CW'(1));
                    idx_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (valid_reg[idx_reg] && (rd_data == page_reg))
                begin
                    ref_next[idx_reg] = 1'b1;
                    pend_hit_next     = 1'b1;
                    pend_slot_next    = idx_reg;
                    state_next        = ST_DONE;
                end
                else if (idx_reg == last_reg)
                begin
                    idx_next   = (hand_reg > last_reg) ? '0 : hand_reg;
                    state_next = ST_SWEEP;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_SWEEP:
            begin
                if (ref_reg[idx_reg])
                begin
                    // Give a second chance and advance
                    ref_next[idx_reg] = 1'b0;
                    idx_next          = idx_inc;
                end
                else
                begin
                    // Place the page here
                    ram_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    hand_next           = idx_inc;
                    pend_hit_next       = 1'b0;
                    pend_slot_next      = idx_reg;
                    if (fault_reg != FAULT_MAX)
                    begin
                        fault_next = fault_reg + fault_t'(1);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = pend_hit_reg;
                    out_slot_next  = SLOT_W'(pend_slot_reg);
                    out_fault_next = fault_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            last_reg      <= '0;
            hand_reg      <= '0;
            valid_reg     <= '0;
            ref_reg       <= '0;
            fault_reg     <= '0;
            frames_reg    <= FRAMES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            fault_reg     <= fault_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        pend_hit_reg  <= pend_hit_next;
        pend_slot_reg <= pend_slot_next;
        out_hit_reg   <= out_hit_next;
        out_slot_reg  <= out_slot_next;
        out_fault_reg <= out_fault_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W - FAULT_W){1'b0}}, out_fault_reg, out_slot_reg};

endmodule

`default_nettype wire

/* rtl/scr_checker.sv */
`default_nettype none

// Port-level checks on the page replacement block
module scr_checker
    import scr_pkg::*;
#(
    parameter int MAX_FRAMES = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]           m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CW = 8;

    logic   seen_reg;
    fault_t prev_fault_reg;
    cfg_t   frames_reg;
    logic   out_xfer;
    fault_t fault_now;
    slot_t  slot_now;
    logic [CW-1:0] n_lim;

    assign out_xfer  = m_tvalid && m_tready;
    assign fault_now = m_tdata[SLOT_W +: FAULT_W];
    assign slot_now  = m_tdata[SLOT_W-1:0];

    // Clamp the tracked frame count
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_lim = CW'(1);
        end
        else if (CW'(frames_reg) > CW'(MAX_FRAMES))
        begin
            n_lim = CW'(MAX_FRAMES);
        end
        else
        begin
            n_lim = CW'(frames_reg);
        end
    end

    // Track the last delivered fault count and the frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_fault_reg <= '0;
            frames_reg     <= FRAMES_RESET;
        end
        else
        begin
            if (out_xfer)
            begin
                seen_reg       <= 1'b1;
                prev_fault_reg <= fault_now;
            end
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= cfg_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second reference taken while one is in work");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && seen_reg && m_tuser[0] |-> fault_now == prev_fault_reg)
        else $error("fault count moved on a hit");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && seen_reg && !m_tuser[0] |->
            (fault_now == prev_fault_reg + fault_t'(1)) ||
            (prev_fault_reg == FAULT_MAX && fault_now == FAULT_MAX))
        else $error("fault count did not advance on a miss");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> CW'(slot_now) < n_lim)
        else $error("frame slot beyond active frames");

endmodule

bind second_chance_page_replacement scr_checker #(
    .MAX_FRAMES (MAX_FRAMES)
) u_scr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire

/* bench/tb_second_chance_page_replacement.sv */
module tb_second_chance_page_replacement
    import scr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES  = 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_MAX  = 40;

    typedef struct packed {
        logic   hit;
        slot_t  slot;
        fault_t faults;
    } page_outcome_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PAGE_IN_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_t                 cfg_data  = '0;

    // Resident-page model: what the block should hold after every reference
    logic [PAGE_IN_W-1:0] res_pages [NUM_FRAMES];
    bit                   res_valid [NUM_FRAMES];
    bit                   ref_bits  [NUM_FRAMES];
    int                   hand_pos;
    fault_t               fault_tally;
    cfg_t                 frames_setting;

    page_outcome_t expected_outcomes [$];

    int  cycle_count        = 0;
    int  mismatch_count     = 0;
    int  refs_sent          = 0;
    int  outcomes_seen      = 0;
    int  hits_predicted     = 0;
    int  cfg_writes         = 0;
    int  input_stall_cycles = 0;
    int  hold_request       = 0;
    int  hold_left          = 0;
    int  ready_gap          = 0;
    bit  src_idling         = 1'b0;
    bit  sink_idling        = 1'b0;

    second_chance_page_replacement #(
        .MAX_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_IN_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_outcomes.size());
            $display("FAIL second_chance_page_replacement");
            $finish;
        end
    end

    // Mostly no gap; short gaps usually, a long one now and then
    function automatic int pick_gap(bit enabled);
        if (!enabled || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Clamp the register to the number of frames actually searched
    function automatic int active_frames_for(cfg_t setting);
        if (setting == 0)
            return 1;
        if (setting > NUM_FRAMES)
            return NUM_FRAMES;
        return setting;
    endfunction

    // Look up one reference, sweep on a fault, and advance the model
    function automatic page_outcome_t resolve_reference(logic [PAGE_IN_W-1:0] page);
        page_outcome_t outcome;
        int            n;
        int            h;
        int            steps;
        n            = active_frames_for(frames_setting);
        outcome.hit  = 1'b0;
        outcome.slot = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!outcome.hit && res_valid[i] && res_pages[i] == page)
            begin
                ref_bits[i]  = 1'b1;
                outcome.hit  = 1'b1;
                outcome.slot = slot_t'(i);
            end
        end
        if (!outcome.hit)
        begin
            h = (hand_pos >= n) ? 0 : hand_pos;
            steps = 0;
            // Give each referenced frame its second chance
            while (steps < 2 * n && ref_bits[h])
            begin
                ref_bits[h] = 1'b0;
                h = (h + 1) % n;
                steps++;
            end
            res_pages[h] = page;
            res_valid[h] = 1'b1;
            outcome.slot = slot_t'(h);
            hand_pos     = (h + 1) % n;
            if (fault_tally != FAULT_MAX)
                fault_tally++;
        end
        else
            hits_predicted++;
        outcome.faults = fault_tally;
        return outcome;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare one output transfer against the oldest prediction
    task automatic check_outcome();
        page_outcome_t want;
        logic          got_hit;
        slot_t         got_slot;
        fault_t        got_faults;
        got_hit    = m_tuser[0];
        got_slot   = m_tdata[SLOT_W-1:0];
        got_faults = m_tdata[SLOT_W +: FAULT_W];
        outcomes_seen++;
        if (expected_outcomes.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: hit %0b slot %0d faults %0d",
                                      got_hit, got_slot, got_faults));
            return;
        end
        want = expected_outcomes.pop_front();
        if (got_hit !== want.hit)
            report_mismatch($sformatf("result %0d hit %b, want %b",
                                      outcomes_seen, got_hit, want.hit));
        if (got_slot !== want.slot)
            report_mismatch($sformatf("result %0d frame %0d, want %0d",
                                      outcomes_seen, got_slot, want.slot));
        if (got_faults !== want.faults)
            report_mismatch($sformatf("result %0d fault count %0d, want %0d",
                                      outcomes_seen, got_faults, want.faults));
    endtask

    // Receive side: check transfers, drive ready with random gaps and long holds
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_outcome();
        if (rst_n && s_tvalid && !s_tready)
            input_stall_cycles++;
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (ready_gap > 0)
        begin
            m_tready <= 1'b0;
            ready_gap--;
        end
        else
        begin
            m_tready  <= 1'b1;
            ready_gap = pick_gap(sink_idling);
        end
    end

    // Offer one page reference and hold it until the transfer
    task automatic send_reference(input logic [PAGE_IN_W-1:0] page);
        int gap;
        gap = pick_gap(src_idling);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        do
            @(posedge clk);
        while (!s_tready);
        expected_outcomes.push_back(resolve_reference(page));
        refs_sent++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_frame_count(input cfg_t count);
        wait_until_idle();
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        frames_setting = count;
        cfg_writes++;
    endtask

    // Fill empty frames at the reset count, then force a sweep past two hit frames
    task automatic test_fill_and_second_chance();
        send_reference(16'h0000);
        send_reference(16'hFFFF);
        send_reference(16'h0000);
        send_reference(16'hFFFF);
        send_reference(16'hAAAA);
        send_reference(16'h5555);
        for (int p = 3; p <= 6; p++)
            send_reference(PAGE_IN_W'(p));
        send_reference(16'h0007);
    endtask

    // Shrink, grow past the maximum and zero the frame count
    task automatic test_frame_count_changes();
        write_frame_count(cfg_t'(2));
        send_reference(16'h0005);
        send_reference(16'hFFFF);
        write_frame_count(cfg_t'(15));
        send_reference(16'h0005);
        send_reference(16'h0006);
        write_frame_count(cfg_t'(0));
        send_reference(16'h1234);
        send_reference(16'h1234);
        write_frame_count(cfg_t'(8));
        send_reference(16'h0006);
    endtask

    // Working sets as large as the frame count or a little larger keep the hand sweeping
    task automatic test_random_traffic();
        cfg_t                 settings [8];
        logic [PAGE_IN_W-1:0] working_set [12];
        logic [PAGE_IN_W-1:0] page;
        int                   ws_size;
        settings[0] = cfg_t'(1);
        settings[1] = cfg_t'(8);
        settings[2] = cfg_t'(0);
        settings[3] = cfg_t'(15);
        for (int p = 4; p < 7; p++)
            settings[p] = cfg_t'($urandom_range(2, 7));
        settings[7] = cfg_t'($urandom_range(9, 14));
        for (int p = 0; p < 8; p++)
        begin
            write_frame_count(settings[p]);
            ws_size = active_frames_for(settings[p]) + $urandom_range(0, 3);
            foreach (working_set[i])
                working_set[i] = PAGE_IN_W'($urandom);
            src_idling  = (p % 3 != 2);
            sink_idling = (p % 4 != 1);
            repeat (225)
            begin
                if ($urandom_range(0, 4) == 0)
                    page = PAGE_IN_W'($urandom);
                else
                    page = working_set[$urandom_range(0, ws_size - 1)];
                send_reference(page);
            end
        end
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_output_backpressure();
        logic [PAGE_IN_W-1:0] pages [6];
        write_frame_count(cfg_t'(4));
        foreach (pages[i])
            pages[i] = PAGE_IN_W'($urandom);
        src_idling   = 1'b0;
        sink_idling  = 1'b0;
        hold_request = 300;
        repeat (24)
            send_reference(pages[$urandom_range(0, 5)]);
        sink_idling = 1'b1;
        src_idling  = 1'b1;
        repeat (24)
            send_reference(pages[$urandom_range(0, 5)]);
    endtask

    // Alternate two pages through one frame at full rate, then repeat one for hits
    task automatic test_single_frame();
        logic [PAGE_IN_W-1:0] page_a;
        logic [PAGE_IN_W-1:0] page_b;
        write_frame_count(cfg_t'(1));
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        page_a      = PAGE_IN_W'($urandom);
        page_b      = ~page_a;
        repeat (10)
        begin
            send_reference(page_a);
            send_reference(page_b);
        end
        sink_idling = 1'b1;
        repeat (4)
            send_reference(page_b);
    endtask

    initial
    begin
        foreach (res_pages[i])
        begin
            res_pages[i] = '0;
            res_valid[i] = 1'b0;
            ref_bits[i]  = 1'b0;
        end
        hand_pos       = 0;
        fault_tally    = '0;
        frames_setting = FRAMES_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_second_chance();
        test_frame_count_changes();
        test_output_backpressure();
        test_random_traffic();
        test_single_frame();

        wait_until_idle();
        repeat (40) @(posedge clk);

        $display("covered %0d references (%0d hits), %0d frame-count writes, fault count at %0d",
                 refs_sent, hits_predicted, cfg_writes, fault_tally);
        $display("input stalled for %0d cycles, %0d mismatches", input_stall_cycles,
                 mismatch_count);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("PASS second_chance_page_replacement");
        else
            $display("FAIL second_chance_page_replacement");
        $finish;
    end

endmodule
